### rtl/smeu_pkg.sv
// smeu_pkg: shared constants and types for the stack machine execution unit
// no dependencies
`timescale 1ns / 1ps
package smeu_pkg;

  localparam int unsigned StackDepthDefault = 256;
  localparam int unsigned WordW = 64;

  typedef enum logic [3:0] {
    OP_PUSH    = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_MUL     = 4'd3,
    OP_DIVMOD  = 4'd4,
    OP_SHUFFLE = 4'd5,
    OP_PICK    = 4'd6,
    OP_DEPTH   = 4'd7,
    OP_POPEMIT = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_BADSHUF = 3'd3,
    ST_DIVZERO = 3'd4
  } status_e;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/smeu_if.sv
// smeu_in_if / smeu_out_if: valid/ready channels of the execution unit
// no dependencies
`timescale 1ns / 1ps
interface smeu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic signed [63:0] push_value;
  modport source (output valid, op, push_value, input ready);
  modport sink (input valid, op, push_value, output ready);
endinterface

interface smeu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        emit_valid;
  logic signed [63:0] emit_value;
  logic [8:0]  depth_after;
  logic signed [63:0] top_after;
  modport source (output valid, status, emit_valid, emit_value, depth_after, top_after,
                  input ready);
  modport sink (input valid, status, emit_valid, emit_value, depth_after, top_after,
                output ready);
endinterface

### rtl/smeu_div.sv
// smeu_div: signed truncating 64-bit divider, one quotient bit per cycle
// depends on smeu_pkg
`timescale 1ns / 1ps
module smeu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smeu_pkg::div_req_t req_i,
  output smeu_pkg::div_rsp_t rsp_o
);
  import smeu_pkg::*;

  logic [WordW-1:0] q_q, q_d, r_q, r_d, b_q, b_d;
  logic             qneg_q, qneg_d, rneg_q, rneg_d;
  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] rsh;

  always_comb begin
    q_d = q_q; r_d = r_q; b_d = b_q; qneg_d = qneg_q; rneg_d = rneg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    rsh = {r_q[WordW-2:0], q_q[WordW-1]};
    trial = {1'b0, rsh} - {1'b0, b_q};
    if (req_i.start) begin
      q_d = req_i.dividend[WordW-1] ? -req_i.dividend : req_i.dividend;
      b_d = req_i.divisor[WordW-1] ? -req_i.divisor : req_i.divisor;
      r_d = '0;
      qneg_d = req_i.dividend[WordW-1] ^ req_i.divisor[WordW-1];
      rneg_d = req_i.dividend[WordW-1];
      cnt_d = 7'(WordW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step: shift in next dividend bit, subtract if it fits
      if (!trial[WordW]) begin
        r_d = trial[WordW-1:0];
        q_d = {q_q[WordW-2:0], 1'b1};
      end else begin
        r_d = rsh;
        q_d = {q_q[WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; b_q <= b_d; qneg_q <= qneg_d; rneg_q <= rneg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = qneg_q ? -q_q : q_q;
  assign rsp_o.rem  = rneg_q ? -r_q : r_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("div done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("div did not start");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("div done twice");
`endif
endmodule

### rtl/stack_machine_execution_unit_core.sv
// stack_machine_execution_unit_core: top level of the stack machine execution unit
// depends on smeu_pkg, smeu_if, smeu_div
`timescale 1ns / 1ps
// usage:
//  in_i carries one primitive per word (op, push_value); out_o returns one
//  result word per primitive (status, emit, depth and top after the step).
//  the unit takes one word at a time: in_i.ready is high only in the idle
//  state, and stays low until the result word has been taken on out_o;
//  the next word can be taken in the cycle after the result word leaves.
//  the stack sits in a memory with one write port and a registered read, so
//  every stack read returns its word registered; the sequencer issues them one by one.
//  mul uses one shared 32x32 multiplier over three partial products;
//  divmod runs the iterative divider after the operand reads and then
//  writes two words; shuffle with C selectors runs a validate pass, a
//  gather pass into a scratch buffer and a write pass.
//  a stalled out_o simply holds the result word; the unit does not accept a
//  new word until it is taken.
//  reset clears the depth and the sequencer; the stack contents are not
//  cleared, since a slot below the depth has always been written.
//  top_after is read back from memory after each step.
module stack_machine_execution_unit_core #(
  parameter int unsigned STACK_DEPTH = smeu_pkg::StackDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  smeu_in_if.sink    in_i,
  smeu_out_if.source out_o
);
  import smeu_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0, S_RD1 = 5'd1, S_RD1W = 5'd2, S_RD2W = 5'd3,
                         S_EXEC = 5'd4, S_DIVW = 5'd5, S_WR2 = 5'd6, S_TOP = 5'd7,
                         S_TOPW = 5'd8, S_OUT = 5'd9, S_VRD = 5'd10, S_VCHK = 5'd11,
                         S_GRD = 5'd12, S_GRDW = 5'd13, S_GPK = 5'd14, S_WRB = 5'd15,
                         S_MUL = 5'd16, S_RD3W = 5'd17;

  logic [WordW-1:0] mem [STACK_DEPTH];
  logic [WordW-1:0] pbuf [STACK_DEPTH];

  logic [4:0]       st_q, st_d;
  logic [DW-1:0]    dep_q, dep_d;
  logic [3:0]       op_q, op_d;
  logic [WordW-1:0] val_q, val_d;
  logic [WordW-1:0] t_q, t_d, s_q, s_d, u_q, u_d; // top, second, third
  logic [2:0]       stat_q, stat_d;
  logic             emv_q, emv_d;
  logic [WordW-1:0] emval_q, emval_d;
  logic [WordW-1:0] topo_q, topo_d;
  logic [DW-1:0]    i_q, i_d;     // shuffle walk index, mul step
  logic [DW-1:0]    o_q, o_d;     // selector block start
  logic [DW:0]      b2_q, b2_d;   // write start

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [WordW-1:0] wdata, rdata_q;
  logic             pwe;
  logic [AW-1:0]    paddr;
  logic [WordW-1:0] pwdata, prdata_q;

  div_req_t dreq;
  div_rsp_t drsp;

  smeu_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // stack memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // shuffle gather buffer
  always_ff @(posedge clk_i) begin
    if (pwe) pbuf[paddr] <= pwdata;
    prdata_q <= pbuf[paddr];
  end

  function automatic logic [AW-1:0] ad(input logic [DW:0] x);
    return x[AW-1:0];
  endfunction

  logic [DW:0] depx;
  logic [WordW-1:0] shr_cnt_lim, prod;
  logic [31:0]      mul_a, mul_b;
  assign depx = {1'b0, dep_q};

  always_comb begin
    st_d = st_q; dep_d = dep_q; op_d = op_q; val_d = val_q;
    t_d = t_q; s_d = s_q; u_d = u_q; stat_d = stat_q; emv_d = emv_q;
    emval_d = emval_q; topo_d = topo_q; i_d = i_q; o_d = o_q; b2_d = b2_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    pwe = 1'b0; paddr = ad({1'b0, i_q}); pwdata = rdata_q;
    dreq = '0;
    // 32x32 partial product: lo*lo, then lo*hi, then hi*lo
    mul_a = (i_q == DW'(2)) ? s_q[63:32] : s_q[31:0];
    mul_b = (i_q == DW'(1)) ? t_q[63:32] : t_q[31:0];
    prod = {32'd0, mul_a} * {32'd0, mul_b};
    shr_cnt_lim = WordW'(dep_q) - 64'd2;
    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d = in_i.op; val_d = in_i.push_value;
          stat_d = ST_OK; emv_d = 1'b0; emval_d = '0;
          st_d = S_RD1;
        end
      end
      S_RD1: begin
        unique case (op_q)
          OP_PUSH, OP_DEPTH: begin
            if (depx >= (DW+1)'(STACK_DEPTH)) begin
              stat_d = ST_OVER; st_d = S_TOP;
            end else begin
              we = 1'b1; waddr = ad(depx);
              wdata = (op_q == OP_PUSH) ? val_q : WordW'(dep_q);
              dep_d = dep_q + DW'(1);
              st_d = S_TOP;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIVMOD, OP_SHUFFLE, OP_PICK: begin
            if (dep_q < DW'(2) || (op_q == OP_PICK && dep_q < DW'(3))) begin
              stat_d = ST_UNDER; st_d = S_TOP;
            end else begin
              raddr = ad(depx - 1'b1); st_d = S_RD1W;
            end
          end
          OP_POPEMIT: begin
            if (dep_q == '0) begin
              stat_d = ST_UNDER; st_d = S_TOP;
            end else begin
              raddr = ad(depx - 1'b1); st_d = S_RD1W;
            end
          end
          default: st_d = S_TOP;
        endcase
      end
      S_RD1W: begin
        t_d = rdata_q;
        if (op_q == OP_POPEMIT) begin
          emv_d = 1'b1; emval_d = rdata_q; dep_d = dep_q - DW'(1); st_d = S_TOP;
        end else begin
          raddr = ad(depx - 2'd2); st_d = S_RD2W;
        end
      end
      S_RD2W: begin
        s_d = rdata_q;
        if (op_q == OP_PICK) begin
          raddr = ad(depx - 2'd3); st_d = S_RD3W;
        end else st_d = S_EXEC;
      end
      S_RD3W: begin
        u_d = rdata_q; st_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_q)
          OP_ADD: begin
            we = 1'b1; waddr = ad(depx - 2'd2); wdata = s_q + t_q;
            dep_d = dep_q - DW'(1); st_d = S_TOP;
          end
          OP_SUB: begin
            we = 1'b1; waddr = ad(depx - 2'd2); wdata = s_q - t_q;
            dep_d = dep_q - DW'(1); st_d = S_TOP;
          end
          OP_MUL: begin
            // product accumulated in u over three steps, then written
            u_d = '0; i_d = '0; st_d = S_MUL;
          end
          OP_DIVMOD: begin
            if (t_q == '0) begin
              stat_d = ST_DIVZERO; st_d = S_TOP;
            end else begin
              dreq.start = 1'b1; dreq.dividend = s_q; dreq.divisor = t_q;
              st_d = S_DIVW;
            end
          end
          OP_PICK: begin
            if (t_q != '0) begin
              we = 1'b1; waddr = ad(depx - 2'd3); wdata = s_q;
            end
            dep_d = dep_q - DW'(2); st_d = S_TOP;
          end
          default: begin
            // shuffle: t is count, s is base
            if (t_q > shr_cnt_lim || s_q > shr_cnt_lim) begin
              stat_d = ST_BADSHUF; st_d = S_TOP;
            end else begin
              o_d = DW'(shr_cnt_lim - t_q);
              b2_d = (DW+1)'(shr_cnt_lim - s_q);
              i_d = '0; st_d = S_VRD;
            end
          end
        endcase
      end
      S_MUL: begin
        if (i_q == DW'(3)) begin
          we = 1'b1; waddr = ad(depx - 2'd2); wdata = u_q;
          dep_d = dep_q - DW'(1); st_d = S_TOP;
        end else begin
          // cross terms only reach the upper half of the wrapped product
          u_d = (i_q == '0) ? prod : u_q + {prod[31:0], 32'd0};
          i_d = i_q + DW'(1);
        end
      end
      S_DIVW: begin
        if (drsp.done) begin
          we = 1'b1; waddr = ad(depx - 2'd2); wdata = drsp.quot;
          t_d = drsp.rem; st_d = S_WR2;
        end
      end
      S_WR2: begin
        we = 1'b1; waddr = ad(depx - 1'b1); wdata = t_q; st_d = S_TOP;
      end
      // validate selectors one per read
      S_VRD: begin
        if ({1'b0, i_q} == (DW+1)'(t_q)) begin
          if (b2_q + (DW+1)'(t_q) > (DW+1)'(STACK_DEPTH)) begin
            stat_d = ST_OVER; st_d = S_TOP;
          end else begin
            i_d = '0; st_d = S_GRD;
          end
        end else begin
          raddr = ad({1'b0, o_q} + {1'b0, i_q}); st_d = S_VCHK;
        end
      end
      S_VCHK: begin
        if (rdata_q == '0 || rdata_q > WordW'(o_q)) begin
          stat_d = ST_BADSHUF; st_d = S_TOP;
        end else begin
          i_d = i_q + DW'(1); st_d = S_VRD;
        end
      end
      // gather picked words into the buffer
      S_GRD: begin
        if ({1'b0, i_q} == (DW+1)'(t_q)) begin
          i_d = '0; st_d = S_WRB;
        end else begin
          raddr = ad({1'b0, o_q} + {1'b0, i_q}); st_d = S_GRDW;
        end
      end
      S_GRDW: begin
        raddr = ad({1'b0, o_q} - (DW+1)'(rdata_q)); st_d = S_GPK;
      end
      S_GPK: begin
        pwe = 1'b1; pwdata = rdata_q; i_d = i_q + DW'(1); st_d = S_GRD;
      end
      // write back: buffer read at i, written the next cycle
      S_WRB: begin
        if (i_q != '0) begin
          we = 1'b1; waddr = ad(b2_q + {1'b0, i_q} - 1'b1); wdata = prdata_q;
        end
        if ({1'b0, i_q} == (DW+1)'(t_q)) begin
          dep_d = DW'(b2_q + (DW+1)'(t_q)); st_d = S_TOP;
        end else i_d = i_q + DW'(1);
      end
      S_TOP: begin
        raddr = ad(depx - 1'b1); st_d = S_TOPW;
      end
      S_TOPW: begin
        topo_d = (dep_q == '0) ? '0 : rdata_q; st_d = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      dep_q <= '0;
    end else begin
      st_q  <= st_d;
      dep_q <= dep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; val_q <= val_d; t_q <= t_d; s_q <= s_d; u_q <= u_d;
    stat_q <= stat_d; emv_q <= emv_d; emval_q <= emval_d; topo_q <= topo_d;
    i_q <= i_d; o_q <= o_d; b2_q <= b2_d;
  end

  assign in_i.ready        = (st_q == S_IDLE);
  assign out_o.valid       = (st_q == S_OUT);
  assign out_o.status      = stat_q;
  assign out_o.emit_valid  = emv_q;
  assign out_o.emit_value  = emval_q;
  assign out_o.depth_after = 9'(dep_q);
  assign out_o.top_after   = topo_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= DW'(STACK_DEPTH)) else $error("depth beyond capacity");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("ready while result pending");
  a_depth_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT || st_q == S_IDLE) |=> $stable(dep_q)) else $error("depth moved idle");
  a_fault_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && stat_q != ST_OK) |-> !emv_q) else $error("emit on fault");
`endif
endmodule
